FILE: rtl/ulc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulc_pkg
// Shared constants and types for the unsorted list with cursor.
// ----------------------------------------------------------------------------
package ulc_pkg;

   localparam int CAPACITY_DEF  = 64;
   localparam int ITEM_BITS_DEF = 32;

   // Port widths of the item and action fields
   localparam int ITEM_W   = 32;
   localparam int ACTION_W = 3;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 3'd0,
      ACT_FIND   = 3'd1,
      ACT_DELETE = 3'd2,
      ACT_FIRST  = 3'd3,
      ACT_NEXT   = 3'd4
   } action_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_DEL   = 6'b000100,
      ST_FETCH = 6'b001000,
      ST_RESP  = 6'b010000,
      ST_SPARE = 6'b100000
   } state_type;

endpackage

FILE: rtl/ulc_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulc_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ulc_store #(
   parameter int CAPACITY  = ulc_pkg::CAPACITY_DEF,
   parameter int ITEM_BITS = ulc_pkg::ITEM_BITS_DEF,
   localparam int ADDR_W   = $clog2(CAPACITY)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [ITEM_BITS-1:0] wr_data,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [ITEM_BITS-1:0] rd_data
);

   logic [ITEM_BITS-1:0] mem [CAPACITY];
   logic [ITEM_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/unsorted_list_with_cursor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsorted_list_with_cursor_unit
// Unordered list of items in one memory, with fill count and cursor.
// Steps: insert and cursor moves pass through FETCH to RESP, delete through DEL first;
//   find scans in SCAN, one entry per cycle through the memory read port, then FETCH.
// Throughput: one word at a time; the next start is taken the cycle after the strobe.
// Reset clears count, cursor and control; entries are undefined until written.
// The result word shows for one cycle on rsp_strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module unsorted_list_with_cursor_unit #(
   parameter int CAPACITY  = ulc_pkg::CAPACITY_DEF,
   parameter int ITEM_BITS = ulc_pkg::ITEM_BITS_DEF,
   localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [ulc_pkg::ACTION_W-1:0] req_action,
   input  logic [ulc_pkg::ITEM_W-1:0]   req_item_value,
   output logic                         rsp_strobe,
   output logic                         rsp_accepted,
   output logic                         rsp_found,
   output logic [ulc_pkg::ITEM_W-1:0]   rsp_cursor_item,
   output logic [CNT_W-1:0]             rsp_entry_count,
   output logic                         rsp_is_full,
   output logic                         rsp_at_last_entry
);
   import ulc_pkg::*;

   localparam int CUR_W = $clog2(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
   localparam logic [CUR_W-1:0] CUR_LAST = CUR_W'(CAPACITY - 1);

   state_type            state_ff,    state_in;
   logic [CNT_W-1:0]     count_ff,    count_in;
   logic [CUR_W-1:0]     cursor_ff,   cursor_in;
   logic [CUR_W-1:0]     chk_ff,      chk_in;
   logic [ITEM_BITS-1:0] item_ff,     item_in;
   logic                 accepted_ff, accepted_in;
   logic                 found_ff,    found_in;

   logic                 wr_en;
   logic [CUR_W-1:0]     wr_addr;
   logic [ITEM_BITS-1:0] wr_data;
   logic [CUR_W-1:0]     rd_addr;
   logic [ITEM_BITS-1:0] rd_data;

   logic [ITEM_BITS-1:0] req_item;
   logic [CNT_W-1:0]     cursor_ext;
   logic                 cursor_valid;

   assign req_item     = ITEM_BITS'(req_item_value);
   assign cursor_ext   = CNT_W'(cursor_ff);
   assign cursor_valid = cursor_ext < count_ff;

   ulc_store #(
      .CAPACITY  (CAPACITY),
      .ITEM_BITS (ITEM_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      cursor_in   = cursor_ff;
      chk_in      = chk_ff;
      item_in     = item_ff;
      accepted_in = accepted_ff;
      found_in    = found_ff;
      wr_en       = 1'b0;
      wr_addr     = cursor_ff;
      wr_data     = rd_data;
      rd_addr     = cursor_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in     = req_item;
               accepted_in = 1'b0;
               found_in    = 1'b0;
               state_in    = ST_FETCH;
               case (action_type'(req_action))
                  ACT_INSERT: begin
                     if (count_ff != CAP_CNT) begin
                        wr_en       = 1'b1;
                        wr_addr     = count_ff[CUR_W-1:0];
                        wr_data     = req_item;
                        count_in    = count_ff + 1'b1;
                        accepted_in = 1'b1;
                     end
                  end
                  ACT_FIND: begin
                     accepted_in = 1'b1;
                     if (count_ff != '0) begin
                        rd_addr  = '0;
                        chk_in   = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  ACT_DELETE: begin
                     if (count_ff != '0 && cursor_valid) begin
                        count_in    = count_ff - 1'b1;
                        // fetch the last entry to move into the hole
                        rd_addr     = count_in[CUR_W-1:0];
                        accepted_in = 1'b1;
                        state_in    = ST_DEL;
                     end
                  end
                  ACT_FIRST: begin
                     cursor_in   = '0;
                     accepted_in = 1'b1;
                  end
                  ACT_NEXT: begin
                     if (cursor_ff != CUR_LAST) begin
                        cursor_in = cursor_ff + 1'b1;
                     end
                     accepted_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // rd_data holds entry chk_ff; read the following one meanwhile
            rd_addr = chk_ff + 1'b1;
            if (rd_data == item_ff) begin
               cursor_in = chk_ff;
               found_in  = 1'b1;
               state_in  = ST_FETCH;
            end else if (CNT_W'(chk_ff) + 1'b1 >= count_ff) begin
               state_in = ST_FETCH;
            end else begin
               chk_in = chk_ff + 1'b1;
            end
         end
         ST_DEL: begin
            wr_en    = 1'b1;
            wr_addr  = cursor_ff;
            wr_data  = rd_data;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            rd_addr  = cursor_ff;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         cursor_ff   <= '0;
         accepted_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         cursor_ff   <= cursor_in;
         accepted_ff <= accepted_in;
         found_ff    <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff  <= chk_in;
      item_ff <= item_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = (state_ff == ST_RESP);
   assign rsp_accepted      = accepted_ff;
   assign rsp_found         = found_ff;
   assign rsp_cursor_item   = cursor_valid ? ITEM_W'(rd_data) : '0;
   assign rsp_entry_count   = count_ff;
   assign rsp_is_full       = (count_ff == CAP_CNT);
   assign rsp_at_last_entry = (count_ff != '0) && (cursor_ext == count_ff - 1'b1);

endmodule
